// ===== rtl/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcs_pkg
// Types and codes for the multicycle processor step block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

   // register file size is fixed by the 3-bit register fields
   localparam int NUM_REGS = 8;

   // item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // opcodes
   localparam logic [3:0] OPC_RTYPE = 4'd0;
   localparam logic [3:0] OPC_JUMP  = 4'd2;
   localparam logic [3:0] OPC_ADDI  = 4'd4;
   localparam logic [3:0] OPC_BEQ   = 4'd8;
   localparam logic [3:0] OPC_LW    = 4'd11;
   localparam logic [3:0] OPC_SW    = 4'd15;

   // alu function codes
   localparam logic [2:0] FN_ADD = 3'd0;
   localparam logic [2:0] FN_SUB = 3'd2;
   localparam logic [2:0] FN_AND = 3'd4;
   localparam logic [2:0] FN_OR  = 3'd5;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  mem_addr;
      logic [15:0] mem_data;
   } mcs_req_type;

   typedef struct packed {
      logic [3:0]         next_phase;
      logic [7:0]         prog_counter;
      logic               halted;
      logic [15:0]        instr_word;
      logic signed [31:0] alu_result;
      logic               zero_flag;
      logic               overflow_flag;
      logic               reg_write;
      logic [2:0]         reg_index;
      logic signed [31:0] reg_value;
   } mcs_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/multicycle_cpu_step.sv =====
// ----------------------------------------------------------------------------
// multicycle_cpu_step
// Multicycle processor for a 16-bit instruction word, one microstate per item.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload        meaning
//  req_      in    mcs_req_type   load a memory word, or advance one microstate
//  rsp_      out   mcs_rsp_type   machine state and write-back after the item
//
//  - an item waits in the input register and then sits in the result register;
//    the result register is loaded at the edge that retires the item
//  - one item per cycle while results are taken; the next memory word and
//    register operands are read as an item retires, so each step sees them ready
//  - a stalled result holds the result register; the input register still
//    takes an item until it is full
//  - synchronous reset clears the machine state and all memory/register valid
//    bits; unwritten entries read as zero, no clearing pass is needed
//
`default_nettype none

module multicycle_cpu_step #(
   parameter int MEM_WORDS  = 256,
   parameter int PROG_WORDS = 128
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  mcs_pkg::mcs_req_type  req_payload,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mcs_pkg::mcs_rsp_type  rsp_payload
);
   import mcs_pkg::*;

   localparam int         MEM_AW   = $clog2(MEM_WORDS);
   localparam logic [8:0] MEM_LIM  = 9'(MEM_WORDS);
   localparam logic [8:0] PROG_LIM = 9'(PROG_WORDS);

   typedef enum logic [3:0] {
      PH_FETCH   = 4'd0,
      PH_DECODE  = 4'd1,
      PH_EXEC    = 4'd2,
      PH_MEMRD   = 4'd3,
      PH_LWWB    = 4'd4,
      PH_SWNOP   = 4'd5,
      PH_ADDIWB  = 4'd6,
      PH_REXEC   = 4'd7,
      PH_RWB     = 4'd8,
      PH_BEQNOP  = 4'd9,
      PH_JUMP    = 4'd10
   } phase_type;

   // {zero, overflow, result}
   function automatic logic [33:0] alu_f(input logic [31:0] x, input logic [31:0] y,
                                         input logic [2:0] op);
      logic [31:0] r;
      logic        zf;
      logic        of;
      r  = '0;
      zf = 1'b0;
      of = 1'b0;
      case (op)
         FN_ADD: begin
            r  = x + y;
            of = ((x[31] ^ r[31]) & (y[31] ^ r[31]));
         end
         FN_SUB: begin
            r  = x - y;
            zf = (r == '0);
            of = ((x[31] ^ y[31]) & (x[31] ^ r[31]));
         end
         FN_AND: r = x & y;
         FN_OR:  r = x | y;
         default: r = '0;
      endcase
      return {zf, of, r};
   endfunction

   // ---------------------------------------------------------------------
   // input register and result register
   // ---------------------------------------------------------------------
   logic        in_vld_ff;
   mcs_req_type in_ff;
   logic        rsp_vld_ff;
   mcs_rsp_type rsp_ff;
   mcs_rsp_type rsp_in;
   logic        proc;

   // the item in the input register retires when the result slot frees up
   assign proc      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || proc;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------------
   // architectural state
   // ---------------------------------------------------------------------
   phase_type   phase_ff, phase_in;
   logic [7:0]  pc_ff, pc_in;
   logic [15:0] ir_ff, ir_in;
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;
   logic [31:0] aluo_ff, aluo_in;
   logic [15:0] mdr_ff, mdr_in;

   // per-item results
   logic        halted;
   logic        zf;
   logic        of;
   logic        wr;
   logic [2:0]  widx;
   logic [31:0] wval;

   // ---------------------------------------------------------------------
   // memory: one write port (load items), one prefetch read port
   // ---------------------------------------------------------------------
   logic [15:0]          mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] mem_vld_ff;
   logic                 mem_we;
   logic [MEM_AW-1:0]    mem_widx;
   logic [7:0]           mem_raddr;
   logic                 mem_rok;
   logic [MEM_AW-1:0]    mem_ridx;
   logic                 mem_byp;
   logic                 mem_hit_ff;
   logic                 mem_byp_ff;
   logic [15:0]          mem_byp_data_ff;
   logic [15:0]          mem_q_ff;
   logic [15:0]          mem_word;

   assign mem_we   = proc && (in_ff.req_type == REQ_LOAD) &&
                     ({1'b0, in_ff.mem_addr} < MEM_LIM);
   assign mem_widx = in_ff.mem_addr[MEM_AW-1:0];

   // the next step needs the fetch word, or the load word in memory read
   assign mem_raddr = (phase_in == PH_MEMRD) ? aluo_in[7:0] : pc_in;
   assign mem_rok   = ({1'b0, mem_raddr} < MEM_LIM);
   assign mem_ridx  = mem_raddr[MEM_AW-1:0];
   assign mem_byp   = mem_we && (mem_widx == mem_ridx);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_widx] <= in_ff.mem_data;
      end
      if (proc) begin
         mem_q_ff        <= mem[mem_ridx];
         mem_byp_data_ff <= in_ff.mem_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
         mem_hit_ff <= 1'b0;
         mem_byp_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            mem_vld_ff[mem_widx] <= 1'b1;
         end
         if (proc) begin
            mem_hit_ff <= mem_rok && (mem_byp || mem_vld_ff[mem_ridx]);
            mem_byp_ff <= mem_byp;
         end
      end
   end

   // unwritten or out-of-range words read as zero
   assign mem_word = !mem_hit_ff ? 16'd0 : (mem_byp_ff ? mem_byp_data_ff : mem_q_ff);

   // ---------------------------------------------------------------------
   // register file: one write port, two prefetch read ports (rs, rt)
   // ---------------------------------------------------------------------
   logic [31:0]         rf [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;
   logic                rf_we;
   logic [2:0]          rs_in;
   logic [2:0]          rt_in;
   logic                rfa_byp_ff, rfb_byp_ff;
   logic                rfa_vld_ff, rfb_vld_ff;
   logic [31:0]         rfa_q_ff, rfb_q_ff;
   logic [31:0]         rf_byp_data_ff;
   logic [31:0]         rf_a;
   logic [31:0]         rf_b;

   assign rf_we = proc && wr;
   assign rs_in = ir_in[11:9];
   assign rt_in = ir_in[8:6];

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[widx] <= wval;
      end
      if (proc) begin
         rfa_q_ff       <= rf[rs_in];
         rfb_q_ff       <= rf[rt_in];
         rf_byp_data_ff <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff  <= '0;
         rfa_byp_ff <= 1'b0;
         rfb_byp_ff <= 1'b0;
         rfa_vld_ff <= 1'b0;
         rfb_vld_ff <= 1'b0;
      end else begin
         if (rf_we) begin
            rf_vld_ff[widx] <= 1'b1;
         end
         if (proc) begin
            rfa_byp_ff <= rf_we && (widx == rs_in);
            rfb_byp_ff <= rf_we && (widx == rt_in);
            rfa_vld_ff <= rf_vld_ff[rs_in];
            rfb_vld_ff <= rf_vld_ff[rt_in];
         end
      end
   end

   assign rf_a = rfa_byp_ff ? rf_byp_data_ff : (rfa_vld_ff ? rfa_q_ff : 32'd0);
   assign rf_b = rfb_byp_ff ? rf_byp_data_ff : (rfb_vld_ff ? rfb_q_ff : 32'd0);

   // ---------------------------------------------------------------------
   // microstate sequencing
   // ---------------------------------------------------------------------
   logic [3:0]  opc;
   logic [2:0]  rd;
   logic [2:0]  fn;
   logic [31:0] imm;
   logic [33:0] alu_res;
   logic        fetch_ok;

   assign opc = ir_ff[15:12];
   assign rd  = ir_ff[5:3];
   assign fn  = ir_ff[2:0];
   assign imm = {{26{ir_ff[5]}}, ir_ff[5:0]};

   // fetch halts on a zero word or a pc outside program or memory
   assign fetch_ok = ({1'b0, pc_ff} < PROG_LIM) && ({1'b0, pc_ff} < MEM_LIM) &&
                     (mem_word != 16'd0);

   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      ir_in    = ir_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      aluo_in  = aluo_ff;
      mdr_in   = mdr_ff;
      halted   = 1'b0;
      zf       = 1'b0;
      of       = 1'b0;
      wr       = 1'b0;
      widx     = 3'd0;
      wval     = 32'd0;
      alu_res  = '0;
      if (in_ff.req_type == REQ_STEP) begin
         case (phase_ff)
            PH_FETCH: begin
               if (fetch_ok) begin
                  ir_in    = mem_word;
                  pc_in    = pc_ff + 8'd1;
                  phase_in = PH_DECODE;
               end else begin
                  halted = 1'b1;
               end
            end
            PH_DECODE: begin
               opa_in  = rf_a;
               opb_in  = rf_b;
               alu_res = alu_f({24'd0, pc_ff}, imm, FN_ADD);
               aluo_in = alu_res[31:0];
               of      = alu_res[32];
               case (opc)
                  OPC_LW, OPC_SW, OPC_ADDI: phase_in = PH_EXEC;
                  OPC_RTYPE:                phase_in = PH_REXEC;
                  OPC_BEQ:                  phase_in = PH_BEQNOP;
                  OPC_JUMP:                 phase_in = PH_JUMP;
                  default:                  phase_in = PH_FETCH;
               endcase
            end
            PH_EXEC: begin
               alu_res = alu_f(opa_ff, imm, FN_ADD);
               aluo_in = alu_res[31:0];
               of      = alu_res[32];
               case (opc)
                  OPC_LW:   phase_in = PH_MEMRD;
                  OPC_SW:   phase_in = PH_SWNOP;
                  OPC_ADDI: phase_in = PH_ADDIWB;
                  default:  phase_in = PH_FETCH;
               endcase
            end
            PH_MEMRD: begin
               mdr_in   = mem_word;
               phase_in = PH_LWWB;
            end
            PH_LWWB: begin
               wr       = 1'b1;
               widx     = ir_ff[8:6];
               wval     = {{16{mdr_ff[15]}}, mdr_ff};
               phase_in = PH_FETCH;
            end
            PH_ADDIWB: begin
               wr       = 1'b1;
               widx     = ir_ff[8:6];
               wval     = aluo_ff;
               phase_in = PH_FETCH;
            end
            PH_REXEC: begin
               alu_res  = alu_f(opa_ff, opb_ff, fn);
               aluo_in  = alu_res[31:0];
               of       = alu_res[32];
               zf       = alu_res[33];
               phase_in = PH_RWB;
            end
            PH_RWB: begin
               wr       = 1'b1;
               widx     = rd;
               wval     = aluo_ff;
               phase_in = PH_FETCH;
            end
            PH_JUMP: begin
               pc_in    = ir_ff[7:0];
               phase_in = PH_FETCH;
            end
            // store and branch no-ops, stray phases
            default: phase_in = PH_FETCH;
         endcase
      end
   end

   always_comb begin
      rsp_in.next_phase    = 4'(phase_in);
      rsp_in.prog_counter  = pc_in;
      rsp_in.halted        = halted;
      rsp_in.instr_word    = ir_in;
      rsp_in.alu_result    = signed'(aluo_in);
      rsp_in.zero_flag     = zf;
      rsp_in.overflow_flag = of;
      rsp_in.reg_write     = wr;
      rsp_in.reg_index     = widx;
      rsp_in.reg_value     = signed'(wval);
   end

   // ---------------------------------------------------------------------
   // state and registered outputs
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         phase_ff   <= PH_FETCH;
         pc_ff      <= 8'd0;
         ir_ff      <= 16'd0;
         opa_ff     <= 32'd0;
         opb_ff     <= 32'd0;
         aluo_ff    <= 32'd0;
         mdr_ff     <= 16'd0;
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (proc) begin
            in_vld_ff <= 1'b0;
         end
         if (proc) begin
            rsp_vld_ff <= 1'b1;
            phase_ff   <= phase_in;
            pc_ff      <= pc_in;
            ir_ff      <= ir_in;
            opa_ff     <= opa_in;
            opb_ff     <= opb_in;
            aluo_ff    <= aluo_in;
            mdr_ff     <= mdr_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (proc) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_halt_in_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.halted |-> rsp_ff.next_phase == 4'(PH_FETCH))
      else $error("halt reported outside fetch");

   a_wb_ends_instr: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.reg_write |-> rsp_ff.next_phase == 4'(PH_FETCH))
      else $error("register write did not return to fetch");

   a_no_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ff.reg_write |-> rsp_ff.reg_index == 3'd0 &&
      rsp_ff.reg_value == 32'sd0)
      else $error("write fields set without register write");

   a_zero_only_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.zero_flag |-> rsp_ff.next_phase == 4'(PH_RWB))
      else $error("zero flag outside r-type execute");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_vld_ff)
      else $error("transfer lost in input register");

endmodule

`default_nettype wire
